[src/mcfp_pkg.sv]
// ----------------------------------------------------------------------------
// mcfp_pkg
// shared types, limits, scaling constants and the crc step for the packer
// ----------------------------------------------------------------------------
package mcfp_pkg;

    // register file
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0]  REG_HEAD_FIRST  = 2'd0;
    localparam logic [1:0]  REG_HEAD_SECOND = 2'd1;
    localparam logic [1:0]  REG_CTRL_MODE   = 2'd2;

    localparam logic [7:0]  HEAD_FIRST_RST  = 8'd254;
    localparam logic [7:0]  HEAD_SECOND_RST = 8'd238;
    localparam logic [3:0]  CTRL_MODE_RST   = 4'd1;

    // clamp limits
    localparam logic signed [15:0] TORQUE_LIMIT   = 16'sd1280;
    localparam logic signed [15:0] POSITION_LIMIT = 16'sd24448;
    localparam logic signed [15:0] SPEED_LIMIT    = 16'sd11520;
    localparam logic [15:0]        STIFF_LIMIT    = 16'd32767;
    localparam logic [15:0]        DAMP_LIMIT     = 16'd6400;

    // unit conversion: q = trunc(x * scale / 62831)
    localparam logic [15:0] DIVISOR     = 16'd62831;
    localparam logic [20:0] POS_SCALE   = 21'd1280000;
    localparam logic [13:0] SPD_SCALE   = 14'd10000;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam logic [20:0] POS_RECIP   =
        21'(64'd1280000 * (64'd1 << RECIP_SHIFT) / 64'd62831);
    localparam logic [13:0] SPD_RECIP   =
        14'(64'd10000 * (64'd1 << RECIP_SHIFT) / 64'd62831);

    // frame byte positions
    localparam logic [4:0] BYTE_HEAD_FIRST  = 5'd0;
    localparam logic [4:0] BYTE_HEAD_SECOND = 5'd1;
    localparam logic [4:0] BYTE_MODE_ID     = 5'd2;
    localparam logic [4:0] BYTE_TORQUE_LO   = 5'd3;
    localparam logic [4:0] BYTE_TORQUE_HI   = 5'd4;
    localparam logic [4:0] BYTE_SPEED_LO    = 5'd5;
    localparam logic [4:0] BYTE_SPEED_HI    = 5'd6;
    localparam logic [4:0] BYTE_POS_0       = 5'd7;
    localparam logic [4:0] BYTE_POS_1       = 5'd8;
    localparam logic [4:0] BYTE_POS_2       = 5'd9;
    localparam logic [4:0] BYTE_POS_3       = 5'd10;
    localparam logic [4:0] BYTE_STIFF_LO    = 5'd11;
    localparam logic [4:0] BYTE_STIFF_HI    = 5'd12;
    localparam logic [4:0] BYTE_DAMP_LO     = 5'd13;
    localparam logic [4:0] BYTE_DAMP_HI     = 5'd14;
    localparam logic [4:0] BYTE_CRC_LO      = 5'd15;
    localparam logic [4:0] BYTE_CRC_HI      = 5'd16;

    localparam logic [15:0] CRC_POLY = 16'h8408;

    typedef struct packed {
        logic [3:0]         motor_addr;
        logic signed [15:0] torque_target;
        logic signed [15:0] position_target;
        logic signed [15:0] speed_target;
        logic [15:0]        stiffness_gain;
        logic [15:0]        damping_gain;
    } cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } frame_t;

    typedef struct packed {
        logic [7:0] head_first;
        logic [7:0] head_second;
        logic [3:0] ctrl_mode;
    } cfg_t;

    // clamped command, speed and position as sign and magnitude
    typedef struct packed {
        logic [3:0]  motor_addr;
        logic [15:0] torque;
        logic        pos_neg;
        logic [14:0] pos_mag;
        logic        spd_neg;
        logic [13:0] spd_mag;
        logic [15:0] stiff;
        logic [15:0] damp;
    } clamp_t;

    // wire-unit words of one frame
    typedef struct packed {
        logic [3:0]  motor_addr;
        logic [15:0] torque;
        logic [15:0] speed;
        logic [31:0] position;
        logic [15:0] stiff;
        logic [15:0] damp;
    } words_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/mcfp_clamp.sv]
// ----------------------------------------------------------------------------
// mcfp_clamp
// one register stage: saturates every command value to its limit
// ----------------------------------------------------------------------------
module mcfp_clamp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mcfp_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output mcfp_pkg::clamp_t out_data
);
    import mcfp_pkg::*;

    logic             valid_reg;
    clamp_t           data_reg;
    clamp_t           data_next;
    logic signed [15:0] pos_c;
    logic signed [15:0] spd_c;

    always_comb
    begin
        data_next.motor_addr = in_cmd.motor_addr;

        if (in_cmd.torque_target > TORQUE_LIMIT)
            data_next.torque = TORQUE_LIMIT;
        else if (in_cmd.torque_target < -TORQUE_LIMIT)
            data_next.torque = -TORQUE_LIMIT;
        else
            data_next.torque = in_cmd.torque_target;

        if (in_cmd.position_target > POSITION_LIMIT)
            pos_c = POSITION_LIMIT;
        else if (in_cmd.position_target < -POSITION_LIMIT)
            pos_c = -POSITION_LIMIT;
        else
            pos_c = in_cmd.position_target;

        if (in_cmd.speed_target > SPEED_LIMIT)
            spd_c = SPEED_LIMIT;
        else if (in_cmd.speed_target < -SPEED_LIMIT)
            spd_c = -SPEED_LIMIT;
        else
            spd_c = in_cmd.speed_target;

        data_next.pos_neg = pos_c[15];
        data_next.pos_mag = pos_c[15] ? 15'(-pos_c) : 15'(pos_c);
        data_next.spd_neg = spd_c[15];
        data_next.spd_mag = spd_c[15] ? 14'(-spd_c) : 14'(spd_c);

        data_next.stiff = (in_cmd.stiffness_gain > STIFF_LIMIT) ? STIFF_LIMIT
                                                                : in_cmd.stiffness_gain;
        data_next.damp  = (in_cmd.damping_gain > DAMP_LIMIT) ? DAMP_LIMIT
                                                             : in_cmd.damping_gain;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

[src/mcfp_scale.sv]
// ----------------------------------------------------------------------------
// mcfp_scale
// three register stages: exact truncating division by 62831 through a
// reciprocal estimate, back-multiply and one-step correction
// ----------------------------------------------------------------------------
module mcfp_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mcfp_pkg::clamp_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mcfp_pkg::words_t  out_data
);
    import mcfp_pkg::*;

    typedef struct packed {
        logic [3:0]  motor_addr;
        logic [15:0] torque;
        logic [15:0] stiff;
        logic [15:0] damp;
        logic        pos_neg;
        logic        spd_neg;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [18:0] pos_q0;
        logic [34:0] pos_n;
        logic [10:0] spd_q0;
        logic [26:0] spd_n;
    } est_t;

    typedef struct packed {
        side_t       side;
        logic [18:0] pos_q0;
        logic [34:0] pos_n;
        logic [34:0] pos_p;
        logic [10:0] spd_q0;
        logic [26:0] spd_n;
        logic [26:0] spd_p;
    } back_t;

    logic   est_valid_reg;
    logic   back_valid_reg;
    logic   word_valid_reg;
    est_t   est_reg;
    est_t   est_next;
    back_t  back_reg;
    back_t  back_next;
    words_t word_reg;
    words_t word_next;

    logic   adv_est;
    logic   adv_back;
    logic   adv_word;

    logic [35:0] pos_prod;
    logic [27:0] spd_prod;
    logic [34:0] pos_r;
    logic [26:0] spd_r;
    logic [18:0] pos_q;
    logic [10:0] spd_q;

    assign adv_word = !word_valid_reg || out_ready;
    assign adv_back = !back_valid_reg || adv_word;
    assign adv_est  = !est_valid_reg  || adv_back;
    assign in_ready = adv_est;

    // quotient estimate, never above the true quotient and at most one below
    always_comb
    begin
        pos_prod = 36'(in_data.pos_mag) * 36'(POS_RECIP);
        spd_prod = 28'(in_data.spd_mag) * 28'(SPD_RECIP);

        est_next.side.motor_addr = in_data.motor_addr;
        est_next.side.torque     = in_data.torque;
        est_next.side.stiff      = in_data.stiff;
        est_next.side.damp       = in_data.damp;
        est_next.side.pos_neg    = in_data.pos_neg;
        est_next.side.spd_neg    = in_data.spd_neg;
        est_next.pos_q0 = pos_prod[RECIP_SHIFT +: 19];
        est_next.spd_q0 = spd_prod[RECIP_SHIFT +: 11];
        est_next.pos_n  = 35'(in_data.pos_mag) * 35'(POS_SCALE);
        est_next.spd_n  = 27'(in_data.spd_mag) * 27'(SPD_SCALE);
    end

    // back-multiply the estimate
    always_comb
    begin
        back_next.side   = est_reg.side;
        back_next.pos_q0 = est_reg.pos_q0;
        back_next.pos_n  = est_reg.pos_n;
        back_next.pos_p  = 35'(est_reg.pos_q0) * 35'(DIVISOR);
        back_next.spd_q0 = est_reg.spd_q0;
        back_next.spd_n  = est_reg.spd_n;
        back_next.spd_p  = 27'(est_reg.spd_q0) * 27'(DIVISOR);
    end

    // correct by one where the remainder still holds a divisor, restore sign
    always_comb
    begin
        pos_r = back_reg.pos_n - back_reg.pos_p;
        spd_r = back_reg.spd_n - back_reg.spd_p;
        pos_q = back_reg.pos_q0 + 19'(pos_r >= 35'(DIVISOR));
        spd_q = back_reg.spd_q0 + 11'(spd_r >= 27'(DIVISOR));

        word_next.motor_addr = back_reg.side.motor_addr;
        word_next.torque     = back_reg.side.torque;
        word_next.stiff      = back_reg.side.stiff;
        word_next.damp       = back_reg.side.damp;
        word_next.position   = back_reg.side.pos_neg ? -32'(pos_q) : 32'(pos_q);
        word_next.speed      = back_reg.side.spd_neg ? -16'(spd_q) : 16'(spd_q);
    end

    assign out_valid = word_valid_reg;
    assign out_data  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg  <= 1'b0;
            back_valid_reg <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_est)
                est_valid_reg <= in_valid;
            if (adv_back)
                back_valid_reg <= est_valid_reg;
            if (adv_word)
                word_valid_reg <= back_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_est && in_valid)
            est_reg <= est_next;
        if (adv_back && est_valid_reg)
            back_reg <= back_next;
        if (adv_word && back_valid_reg)
            word_reg <= word_next;
    end

endmodule

[src/mcfp_serializer.sv]
// ----------------------------------------------------------------------------
// mcfp_serializer
// holds one frame and sends it a byte per transfer, folding the crc as it goes
// ----------------------------------------------------------------------------
module mcfp_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  mcfp_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  mcfp_pkg::words_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output mcfp_pkg::frame_t out_data
);
    import mcfp_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    logic [4:0]  idx_reg;
    logic [4:0]  idx_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    words_t      words_reg;
    cfg_t        cfg_reg;

    logic        out_fire;
    logic        last;
    logic        load;
    logic [7:0]  cur_byte;

    assign last     = (idx_reg == BYTE_CRC_HI);
    assign out_fire = busy_reg && !out_stall;
    assign in_ready = !busy_reg || (out_fire && last);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        case (idx_reg)
            BYTE_HEAD_FIRST:  cur_byte = cfg_reg.head_first;
            BYTE_HEAD_SECOND: cur_byte = cfg_reg.head_second;
            BYTE_MODE_ID:     cur_byte = {cfg_reg.ctrl_mode, words_reg.motor_addr};
            BYTE_TORQUE_LO:   cur_byte = words_reg.torque[7:0];
            BYTE_TORQUE_HI:   cur_byte = words_reg.torque[15:8];
            BYTE_SPEED_LO:    cur_byte = words_reg.speed[7:0];
            BYTE_SPEED_HI:    cur_byte = words_reg.speed[15:8];
            BYTE_POS_0:       cur_byte = words_reg.position[7:0];
            BYTE_POS_1:       cur_byte = words_reg.position[15:8];
            BYTE_POS_2:       cur_byte = words_reg.position[23:16];
            BYTE_POS_3:       cur_byte = words_reg.position[31:24];
            BYTE_STIFF_LO:    cur_byte = words_reg.stiff[7:0];
            BYTE_STIFF_HI:    cur_byte = words_reg.stiff[15:8];
            BYTE_DAMP_LO:     cur_byte = words_reg.damp[7:0];
            BYTE_DAMP_HI:     cur_byte = words_reg.damp[15:8];
            BYTE_CRC_LO:      cur_byte = crc_reg[7:0];
            BYTE_CRC_HI:      cur_byte = crc_reg[15:8];
            default:          cur_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = BYTE_HEAD_FIRST;
            crc_next  = 16'd0;
        end
        else if (out_fire)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 5'd1;
            if (idx_reg < BYTE_CRC_LO)
                crc_next = crc_add(crc_reg, cur_byte);
        end
    end

    assign out_valid           = busy_reg;
    assign out_data.frame_byte = cur_byte;
    assign out_data.frame_last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= BYTE_HEAD_FIRST;
            crc_reg  <= 16'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= in_data;
            cfg_reg   <= cfg;
        end
    end

endmodule

[src/motor_command_frame_packer.sv]
// ----------------------------------------------------------------------------
// motor_command_frame_packer
// clamps a motor command, converts speed and position to wire units and
// sends it as a 17-byte frame closed by a reflected crc-16
// ----------------------------------------------------------------------------
// path: the first frame byte is offered after the command passes the clamp
//   and divide registers and the frame load (clamp 1, divide 3, frame load 1)
// frames: the next frame loads only as the last byte transfers; while one
//   frame is sent, the four stages ahead of it hold up to four further commands
// reset: rst_n clears all valid bits and the serializer; registers return
//   to head 254 / 238 and mode 1
module motor_command_frame_packer (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  mcfp_pkg::cmd_t                cmd,
    // frame byte channel
    output logic                          frame_valid,
    input  logic                          frame_stall,
    output mcfp_pkg::frame_t              frame,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mcfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mcfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import mcfp_pkg::*;

    // register file
    logic [7:0] head_first_reg;
    logic [7:0] head_second_reg;
    logic [3:0] ctrl_mode_reg;
    logic       cfg_write;
    logic [1:0] reg_sel;
    cfg_t       cfg;

    // inter-stage handshakes
    logic       clamp_ready;
    logic       clamp_valid;
    clamp_t     clamp_data;
    logic       scale_ready;
    logic       scale_valid;
    words_t     scale_data;
    logic       ser_ready;

    // apb: always ready, write lands in the access phase
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_first_reg  <= HEAD_FIRST_RST;
            head_second_reg <= HEAD_SECOND_RST;
            ctrl_mode_reg   <= CTRL_MODE_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_HEAD_FIRST:  head_first_reg  <= pwdata[7:0];
                REG_HEAD_SECOND: head_second_reg <= pwdata[7:0];
                REG_CTRL_MODE:   ctrl_mode_reg   <= pwdata[3:0];
                default:         ;
            endcase
        end
    end

    // read mux, unmapped addresses read as zero
    always_comb
    begin
        case (reg_sel)
            REG_HEAD_FIRST:  prdata = {24'd0, head_first_reg};
            REG_HEAD_SECOND: prdata = {24'd0, head_second_reg};
            REG_CTRL_MODE:   prdata = {28'd0, ctrl_mode_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.head_first  = head_first_reg;
    assign cfg.head_second = head_second_reg;
    assign cfg.ctrl_mode   = ctrl_mode_reg;

    // stage 1: saturate every value field, the motor address passes through
    assign cmd_stall = !clamp_ready;

    mcfp_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_ready  (clamp_ready),
        .in_cmd    (cmd),
        .out_valid (clamp_valid),
        .out_ready (scale_ready),
        .out_data  (clamp_data)
    );

    // stages 2-4: reciprocal estimate, back-multiply, correction and sign
    mcfp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clamp_valid),
        .in_ready  (scale_ready),
        .in_data   (clamp_data),
        .out_valid (scale_valid),
        .out_ready (ser_ready),
        .out_data  (scale_data)
    );

    // stage 5: frame assembly, one byte per transfer, crc folded on the fly
    mcfp_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (scale_valid),
        .in_ready  (ser_ready),
        .in_data   (scale_data),
        .out_valid (frame_valid),
        .out_stall (frame_stall),
        .out_data  (frame)
    );

endmodule
